FILE: src/pdll_pkg.sv
`default_nettype none
package pdll_pkg;

	localparam int NODES   = 256;
	localparam int NODE_AW = 8;
	localparam int PTR_W   = 9;
	localparam int LISTS   = 16;
	localparam int LIST_AW = 4;
	localparam int LPTR_W  = 5;
	localparam int ITEM_W  = 32;
	localparam int CNT_W   = 9;
	localparam int OP_W    = 4;

	localparam logic [PTR_W-1:0]  NODE_NULL = PTR_W'(NODES);
	localparam logic [PTR_W-1:0]  NODE_LAST = PTR_W'(NODES - 1);
	localparam logic [LPTR_W-1:0] LIST_NULL = LPTR_W'(LISTS);

	typedef enum logic [OP_W-1:0] {
		OP_CREATE     = 4'd0,
		OP_COUNT      = 4'd1,
		OP_FIRST      = 4'd2,
		OP_LAST       = 4'd3,
		OP_NEXT       = 4'd4,
		OP_PREV       = 4'd5,
		OP_CURR       = 4'd6,
		OP_APPEND     = 4'd7,
		OP_PREPEND    = 4'd8,
		OP_INS_AFTER  = 4'd9,
		OP_INS_BEFORE = 4'd10,
		OP_REMOVE     = 4'd11,
		OP_TRIM       = 4'd12,
		OP_CONCAT     = 4'd13,
		OP_FREE       = 4'd14
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_MOVE_RD,
		ST_MOVE_WT,
		ST_VAL_RD,
		ST_VAL_WT,
		ST_INS_RD,
		ST_INS_W1,
		ST_INS_W2,
		ST_CUT_RD,
		ST_CUT_WR,
		ST_CAT,
		ST_FREE_RD,
		ST_FREE_WT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [PTR_W-1:0]  val_ra;
		logic [PTR_W-1:0]  fwd_ra;
		logic [PTR_W-1:0]  bwd_ra;
		logic [PTR_W-1:0]  link_ra;
		logic              val_we;
		logic [PTR_W-1:0]  val_wa;
		logic [ITEM_W-1:0] val_wd;
		logic              fwd_we;
		logic [PTR_W-1:0]  fwd_wa;
		logic [PTR_W-1:0]  fwd_wd;
		logic              bwd_we;
		logic [PTR_W-1:0]  bwd_wa;
		logic [PTR_W-1:0]  bwd_wd;
		logic              link_we;
		logic [PTR_W-1:0]  link_wa;
		logic [PTR_W-1:0]  link_wd;
	} node_cmd_t;

	typedef struct packed {
		logic [ITEM_W-1:0] val;
		logic [PTR_W-1:0]  fwd;
		logic [PTR_W-1:0]  bwd;
		logic [PTR_W-1:0]  link;
	} node_rsp_t;

endpackage
`default_nettype wire

FILE: src/pooled_doubly_linked_list_unit.sv
// Pooled doubly linked lists: 16 list handles share a pool of 256 nodes, each node
// holding one 32-bit item. One input transaction carries an opcode, a list handle,
// a second handle (concat) and an item word; exactly one result transaction comes out.
// Both channels use valid/ready. One operation is in flight at a time: in_ready is
// high only while the unit is idle, and an operation runs as a short sequence of
// reads and writes on the node memories, one synchronous read per dependent pointer.
// Free walks the list node by node, following each node's forward pointer and
// returning the node to the node free chain.
// The result is held in an output register; a stalled receiver keeps it
// there and the unit waits in its response state until the register is free.
// Reset clears the list table and both free chains at once: the node free chain is
// built lazily through a fill mark, so no clearing pass is needed after reset.
`default_nettype none
module pooled_doubly_linked_list_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [pdll_pkg::OP_W-1:0]       opcode,
	input  wire [pdll_pkg::LIST_AW-1:0]    list_handle,
	input  wire [pdll_pkg::LIST_AW-1:0]    second_handle,
	input  wire [pdll_pkg::ITEM_W-1:0]     item_word,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic                           status,
	output logic [pdll_pkg::ITEM_W-1:0]    result_item,
	output logic [pdll_pkg::CNT_W-1:0]     result_count,
	output logic [pdll_pkg::LIST_AW-1:0]   new_handle
);
	import pdll_pkg::*;

	state_t state_q, state_d;

	logic [OP_W-1:0]    op_q;
	logic [LIST_AW-1:0] h_q, g_q, newh_q;
	logic [ITEM_W-1:0]  v_q, item_q;
	logic [PTR_W-1:0]   a_q, p_q, n_q, pool_q, fresh_q;
	logic [CNT_W-1:0]   lenh_q;
	logic               mid_q, after_q, st_q, bad_q;

	logic [PTR_W-1:0]   head_q [LISTS];
	logic [PTR_W-1:0]   tail_q [LISTS];
	logic [PTR_W-1:0]   cur_q  [LISTS];
	logic [CNT_W-1:0]   len_q  [LISTS];
	logic               past_q [LISTS];
	logic               inuse_q[LISTS];
	logic [LPTR_W-1:0]  lnext_q[LISTS];
	logic [LPTR_W-1:0]  lhead_q;

	logic               out_valid_q, status_q;
	logic [ITEM_W-1:0]  result_item_q;
	logic [CNT_W-1:0]   result_count_q;
	logic [LIST_AW-1:0] new_handle_q;

	node_cmd_t cmd;
	node_rsp_t rsp;

	pdll_node_mem u_mem (
		.clk (clk),
		.cmd (cmd),
		.rsp (rsp)
	);

	op_t              op;
	logic [LIST_AW-1:0] lidx;
	logic [PTR_W-1:0] hd, tl, cu;
	logic [CNT_W-1:0] ln;
	logic             ps, hd_null, tl_null, cu_null, pool_null;
	logic [PTR_W-1:0] dec_p, dec_n, ins_p, ins_n, lk;
	logic             dec_mid, fresh_hit, out_free;

	assign op        = op_t'(op_q);
	assign lidx      = (state_q == ST_CAT) ? g_q : h_q;
	assign hd        = head_q[lidx];
	assign tl        = tail_q[lidx];
	assign cu        = cur_q[lidx];
	assign ln        = len_q[lidx];
	assign ps        = past_q[lidx];
	assign hd_null   = hd[PTR_W-1];
	assign tl_null   = tl[PTR_W-1];
	assign cu_null   = cu[PTR_W-1];
	assign pool_null = pool_q[PTR_W-1];
	assign out_free  = !out_valid_q || out_ready;

	// nodes at or above the fill mark were never handed out: their chain link is implicit
	assign fresh_hit = (pool_q >= fresh_q);
	assign lk = fresh_hit ? ((pool_q == NODE_LAST) ? NODE_NULL : pool_q + PTR_W'(1)) : rsp.link;

	assign ins_p = (mid_q && !after_q) ? rsp.bwd : p_q;
	assign ins_n = (mid_q && after_q) ? rsp.fwd : n_q;

	// neighbors of the new node; default is adding at the tail
	always_comb begin
		dec_p   = tl;
		dec_n   = NODE_NULL;
		dec_mid = 1'b0;
		case (op)
			OP_PREPEND: begin
				dec_p = NODE_NULL;
				dec_n = hd;
			end
			OP_INS_AFTER: begin
				if (ln == '0) begin
					dec_p = tl;
				end else if (cu_null && !ps) begin
					dec_p = NODE_NULL;
					dec_n = hd;
				end else if (cu_null || cu == tl) begin
					dec_p = tl;
				end else begin
					dec_p   = cu;
					dec_mid = 1'b1;
				end
			end
			OP_INS_BEFORE: begin
				if (ln == '0) begin
					dec_p = tl;
				end else if ((cu_null && !ps) || cu == hd) begin
					dec_p = NODE_NULL;
					dec_n = hd;
				end else if (cu_null) begin
					dec_p = tl;
				end else begin
					dec_p   = NODE_NULL;
					dec_n   = cu;
					dec_mid = 1'b1;
				end
			end
			default: begin
				dec_p = tl;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.val_ra  = a_q;
		cmd.fwd_ra  = a_q;
		cmd.bwd_ra  = a_q;
		cmd.link_ra = pool_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DEC;
			end
			ST_DEC: begin
				state_d = ST_RESP;
				if (op != OP_CREATE && inuse_q[h_q]) begin
					case (op)
						OP_FIRST:      state_d = hd_null ? ST_RESP : ST_VAL_RD;
						OP_LAST:       state_d = tl_null ? ST_RESP : ST_VAL_RD;
						OP_NEXT: begin
							if (cu == tl)
								state_d = ST_RESP;
							else if (cu_null)
								state_d = ps ? ST_RESP : ST_VAL_RD;
							else
								state_d = ST_MOVE_RD;
						end
						OP_PREV: begin
							if (cu == hd)
								state_d = ST_RESP;
							else if (cu_null)
								state_d = ps ? ST_VAL_RD : ST_RESP;
							else
								state_d = ST_MOVE_RD;
						end
						OP_CURR:       state_d = cu_null ? ST_RESP : ST_VAL_RD;
						OP_APPEND, OP_PREPEND, OP_INS_AFTER, OP_INS_BEFORE:
							state_d = pool_null ? ST_RESP : ST_INS_RD;
						OP_REMOVE:     state_d = cu_null ? ST_RESP : ST_CUT_RD;
						OP_TRIM:       state_d = tl_null ? ST_RESP : ST_CUT_RD;
						OP_CONCAT:     state_d = (g_q == h_q) ? ST_RESP : ST_CAT;
						OP_FREE:       state_d = ST_FREE_RD;
						default:       state_d = ST_RESP;
					endcase
				end
			end
			ST_MOVE_RD: state_d = ST_MOVE_WT;
			ST_MOVE_WT: begin
				cmd.val_ra = (op == OP_NEXT) ? rsp.fwd : rsp.bwd;
				state_d    = ST_VAL_WT;
			end
			ST_VAL_RD: state_d = ST_VAL_WT;
			ST_VAL_WT: state_d = ST_RESP;
			ST_INS_RD: state_d = ST_INS_W1;
			ST_INS_W1: begin
				cmd.val_we = 1'b1;
				cmd.val_wa = pool_q;
				cmd.val_wd = v_q;
				cmd.fwd_we = 1'b1;
				cmd.fwd_wa = pool_q;
				cmd.fwd_wd = ins_n;
				cmd.bwd_we = 1'b1;
				cmd.bwd_wa = pool_q;
				cmd.bwd_wd = ins_p;
				state_d    = ST_INS_W2;
			end
			ST_INS_W2: begin
				cmd.fwd_we = !p_q[PTR_W-1];
				cmd.fwd_wa = p_q;
				cmd.fwd_wd = a_q;
				cmd.bwd_we = !n_q[PTR_W-1];
				cmd.bwd_wa = n_q;
				cmd.bwd_wd = a_q;
				state_d    = ST_RESP;
			end
			ST_CUT_RD: state_d = ST_CUT_WR;
			ST_CUT_WR: begin
				cmd.fwd_we  = !rsp.bwd[PTR_W-1];
				cmd.fwd_wa  = rsp.bwd;
				cmd.fwd_wd  = rsp.fwd;
				cmd.bwd_we  = !rsp.fwd[PTR_W-1];
				cmd.bwd_wa  = rsp.fwd;
				cmd.bwd_wd  = rsp.bwd;
				cmd.link_we = 1'b1;
				cmd.link_wa = a_q;
				cmd.link_wd = pool_q;
				state_d     = ST_RESP;
			end
			ST_CAT: begin
				// here hd/tl belong to the second list; p_q/n_q hold the first list's ends
				if (inuse_q[g_q] && !hd_null && !p_q[PTR_W-1]) begin
					cmd.fwd_we = 1'b1;
					cmd.fwd_wa = n_q;
					cmd.fwd_wd = hd;
					cmd.bwd_we = 1'b1;
					cmd.bwd_wa = hd;
					cmd.bwd_wd = n_q;
				end
				state_d = ST_RESP;
			end
			ST_FREE_RD: begin
				if (a_q[PTR_W-1]) begin
					state_d = ST_RESP;
				end else begin
					cmd.link_we = 1'b1;
					cmd.link_wa = a_q;
					cmd.link_wd = pool_q;
					state_d     = ST_FREE_WT;
				end
			end
			ST_FREE_WT: state_d = ST_FREE_RD;
			ST_RESP: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				head_q[i]  <= NODE_NULL;
				tail_q[i]  <= NODE_NULL;
				cur_q[i]   <= NODE_NULL;
				len_q[i]   <= '0;
				past_q[i]  <= 1'b0;
				inuse_q[i] <= 1'b0;
				lnext_q[i] <= (i + 1 < LISTS) ? LPTR_W'(i + 1) : LIST_NULL;
			end
			lhead_q     <= '0;
			pool_q      <= '0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == ST_RESP && out_free) || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						h_q    <= list_handle;
						g_q    <= second_handle;
						v_q    <= item_word;
						st_q   <= 1'b1;
						item_q <= '0;
						bad_q  <= 1'b0;
						newh_q <= '0;
						mid_q  <= 1'b0;
					end
				end
				ST_DEC: begin
					if (op == OP_CREATE) begin
						if (!lhead_q[LPTR_W-1]) begin
							h_q     <= lhead_q[LIST_AW-1:0];
							newh_q  <= lhead_q[LIST_AW-1:0];
							lhead_q <= lnext_q[lhead_q[LIST_AW-1:0]];
							inuse_q[lhead_q[LIST_AW-1:0]] <= 1'b1;
							st_q    <= 1'b0;
						end else begin
							bad_q <= 1'b1;
						end
					end else if (!inuse_q[h_q]) begin
						bad_q <= 1'b1;
					end else begin
						case (op)
							OP_COUNT: st_q <= 1'b0;
							OP_FIRST: begin
								cur_q[h_q] <= hd;
								a_q        <= hd;
							end
							OP_LAST: begin
								cur_q[h_q] <= tl;
								a_q        <= tl;
							end
							OP_NEXT: begin
								if (cu == tl) begin
									past_q[h_q] <= 1'b1;
									cur_q[h_q]  <= NODE_NULL;
								end else if (cu_null) begin
									if (!ps) begin
										cur_q[h_q] <= hd;
										a_q        <= hd;
									end
								end else begin
									a_q <= cu;
								end
							end
							OP_PREV: begin
								if (cu == hd) begin
									past_q[h_q] <= 1'b0;
									cur_q[h_q]  <= NODE_NULL;
								end else if (cu_null) begin
									if (ps) begin
										cur_q[h_q] <= tl;
										a_q        <= tl;
									end
								end else begin
									a_q <= cu;
								end
							end
							OP_CURR: a_q <= cu;
							OP_APPEND, OP_PREPEND, OP_INS_AFTER, OP_INS_BEFORE: begin
								p_q     <= dec_p;
								n_q     <= dec_n;
								mid_q   <= dec_mid;
								after_q <= (op == OP_INS_AFTER);
								a_q     <= cu;
							end
							OP_REMOVE: a_q <= cu;
							OP_TRIM:   a_q <= tl;
							OP_CONCAT: begin
								p_q    <= hd;
								n_q    <= tl;
								lenh_q <= ln;
							end
							OP_FREE:   a_q <= hd;
							default:   bad_q <= 1'b1;
						endcase
					end
				end
				ST_MOVE_WT: begin
					cur_q[h_q] <= (op == OP_NEXT) ? rsp.fwd : rsp.bwd;
				end
				ST_VAL_WT: begin
					item_q <= rsp.val;
					st_q   <= 1'b0;
				end
				ST_INS_W1: begin
					a_q    <= pool_q;
					p_q    <= ins_p;
					n_q    <= ins_n;
					pool_q <= lk;
					if (fresh_hit)
						fresh_q <= pool_q + PTR_W'(1);
				end
				ST_INS_W2: begin
					if (p_q[PTR_W-1])
						head_q[h_q] <= a_q;
					if (n_q[PTR_W-1])
						tail_q[h_q] <= a_q;
					cur_q[h_q] <= a_q;
					len_q[h_q] <= len_q[h_q] + CNT_W'(1);
					st_q       <= 1'b0;
				end
				ST_CUT_WR: begin
					if (rsp.bwd[PTR_W-1])
						head_q[h_q] <= rsp.fwd;
					if (rsp.fwd[PTR_W-1])
						tail_q[h_q] <= rsp.bwd;
					if (op == OP_TRIM) begin
						cur_q[h_q]  <= rsp.bwd;
						past_q[h_q] <= 1'b1;
					end else begin
						cur_q[h_q] <= rsp.fwd;
						if (rsp.fwd[PTR_W-1])
							past_q[h_q] <= 1'b1;
					end
					len_q[h_q] <= len_q[h_q] - CNT_W'(1);
					pool_q     <= a_q;
					item_q     <= rsp.val;
					st_q       <= 1'b0;
				end
				ST_CAT: begin
					if (inuse_q[g_q]) begin
						if (!hd_null) begin
							if (p_q[PTR_W-1])
								head_q[h_q] <= hd;
							tail_q[h_q] <= tl;
						end
						len_q[h_q]   <= lenh_q + ln;
						head_q[g_q]  <= NODE_NULL;
						tail_q[g_q]  <= NODE_NULL;
						cur_q[g_q]   <= NODE_NULL;
						past_q[g_q]  <= 1'b0;
						len_q[g_q]   <= '0;
						inuse_q[g_q] <= 1'b0;
						lnext_q[g_q] <= lhead_q;
						lhead_q      <= {1'b0, g_q};
						st_q         <= 1'b0;
					end
				end
				ST_FREE_RD: begin
					if (a_q[PTR_W-1]) begin
						head_q[h_q]  <= NODE_NULL;
						tail_q[h_q]  <= NODE_NULL;
						cur_q[h_q]   <= NODE_NULL;
						past_q[h_q]  <= 1'b0;
						len_q[h_q]   <= '0;
						inuse_q[h_q] <= 1'b0;
						lnext_q[h_q] <= lhead_q;
						lhead_q      <= {1'b0, h_q};
						st_q         <= 1'b0;
					end else begin
						pool_q <= a_q;
					end
				end
				ST_FREE_WT: a_q <= rsp.fwd;
				ST_RESP: begin
					if (out_free) begin
						status_q       <= st_q;
						result_item_q  <= st_q ? '0 : item_q;
						result_count_q <= bad_q ? '0 : len_q[h_q];
						new_handle_q   <= newh_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_item  = result_item_q;
	assign result_count = result_count_q;
	assign new_handle   = new_handle_q;

endmodule
`default_nettype wire

FILE: src/pdll_node_mem.sv
`default_nettype none
module pdll_node_mem (
	input  wire                  clk,
	input  pdll_pkg::node_cmd_t  cmd,
	output pdll_pkg::node_rsp_t  rsp
);
	import pdll_pkg::*;

	logic [ITEM_W-1:0] val_mem  [NODES];
	logic [PTR_W-1:0]  fwd_mem  [NODES];
	logic [PTR_W-1:0]  bwd_mem  [NODES];
	logic [PTR_W-1:0]  link_mem [NODES];

	always_ff @(posedge clk) begin
		if (cmd.val_we)
			val_mem[cmd.val_wa[NODE_AW-1:0]] <= cmd.val_wd;
		if (cmd.fwd_we)
			fwd_mem[cmd.fwd_wa[NODE_AW-1:0]] <= cmd.fwd_wd;
		if (cmd.bwd_we)
			bwd_mem[cmd.bwd_wa[NODE_AW-1:0]] <= cmd.bwd_wd;
		if (cmd.link_we)
			link_mem[cmd.link_wa[NODE_AW-1:0]] <= cmd.link_wd;
		rsp.val  <= val_mem[cmd.val_ra[NODE_AW-1:0]];
		rsp.fwd  <= fwd_mem[cmd.fwd_ra[NODE_AW-1:0]];
		rsp.bwd  <= bwd_mem[cmd.bwd_ra[NODE_AW-1:0]];
		rsp.link <= link_mem[cmd.link_ra[NODE_AW-1:0]];
	end

endmodule
`default_nettype wire

FILE: src/pdll_checker.sv
`default_nettype none
module pdll_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire                          status,
	input wire [pdll_pkg::ITEM_W-1:0]   result_item,
	input wire [pdll_pkg::CNT_W-1:0]    result_count,
	input wire [pdll_pkg::LIST_AW-1:0]  new_handle
);
	import pdll_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one transaction at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	a_fail_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_item == '0)
		else $error("failed result carries an item");

	// a fresh nonzero handle always starts as an empty list
	a_create_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_handle != '0 |-> !status && result_count == '0)
		else $error("bad create result");

endmodule

bind pooled_doubly_linked_list_unit pdll_checker u_pdll_checker (.*);
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pdll_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEF = 4'd15;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic              status;
		logic [ITEM_W-1:0] item;
		logic [CNT_W-1:0]  count;
		logic [3:0]        handle;
	} list_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     opcode = '0;
	logic [3:0]          list_handle = '0;
	logic [3:0]          second_handle = '0;
	logic [ITEM_W-1:0]   item_word = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                status;
	logic [ITEM_W-1:0]   result_item;
	logic [CNT_W-1:0]    result_count;
	logic [3:0]          new_handle;

	pooled_doubly_linked_list_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .list_handle(list_handle),
		.second_handle(second_handle), .item_word(item_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_item(result_item),
		.result_count(result_count), .new_handle(new_handle)
	);

	always #1 clk = ~clk;

	// shadow copy of the list unit; index NODES / LISTS is the null slot
	logic [ITEM_W-1:0] nd_val [0:NODES];
	logic [PTR_W-1:0]  nd_fwd [0:NODES];
	logic [PTR_W-1:0]  nd_bwd [0:NODES];
	logic [PTR_W-1:0]  nd_link[0:NODES];
	logic [PTR_W-1:0]  free_node_head;
	logic [PTR_W-1:0]  ls_head[0:LISTS];
	logic [PTR_W-1:0]  ls_tail[0:LISTS];
	logic [PTR_W-1:0]  ls_cur [0:LISTS];
	logic              ls_past[0:LISTS];
	logic [CNT_W-1:0]  ls_len [0:LISTS];
	logic [LPTR_W-1:0] ls_link[0:LISTS];
	logic              ls_live[0:LISTS];
	logic [LPTR_W-1:0] free_list_head;

	list_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;

	initial begin
		for (int i = 0; i <= NODES; i++) begin
			nd_val[i] = '0;
			nd_fwd[i] = NODE_NULL;
			nd_bwd[i] = NODE_NULL;
			nd_link[i] = (i + 1 < NODES) ? PTR_W'(i + 1) : NODE_NULL;
		end
		free_node_head = '0;
		for (int i = 0; i <= LISTS; i++) begin
			ls_head[i] = NODE_NULL;
			ls_tail[i] = NODE_NULL;
			ls_cur[i] = NODE_NULL;
			ls_past[i] = 1'b0;
			ls_len[i] = '0;
			ls_live[i] = 1'b0;
			ls_link[i] = (i + 1 < LISTS) ? LPTR_W'(i + 1) : LIST_NULL;
		end
		free_list_head = '0;
	end

	function automatic logic [PTR_W-1:0] take_node(logic [ITEM_W-1:0] v);
		logic [PTR_W-1:0] n;
		n = free_node_head;
		if (n == NODE_NULL)
			return NODE_NULL;
		free_node_head = nd_link[n];
		nd_val[n] = v;
		nd_fwd[n] = NODE_NULL;
		nd_bwd[n] = NODE_NULL;
		return n;
	endfunction

	function automatic void return_node(logic [PTR_W-1:0] n);
		if (n == NODE_NULL)
			return;
		nd_fwd[n] = NODE_NULL;
		nd_bwd[n] = NODE_NULL;
		nd_link[n] = free_node_head;
		free_node_head = n;
	endfunction

	function automatic void release_list(int h);
		ls_head[h] = NODE_NULL;
		ls_tail[h] = NODE_NULL;
		ls_cur[h] = NODE_NULL;
		ls_past[h] = 1'b0;
		ls_len[h] = '0;
		ls_live[h] = 1'b0;
		ls_link[h] = free_list_head;
		free_list_head = LPTR_W'(h);
	endfunction

	function automatic logic push_tail(int h, logic [ITEM_W-1:0] v);
		logic [PTR_W-1:0] n;
		n = take_node(v);
		if (n == NODE_NULL)
			return 1'b1;
		nd_bwd[n] = ls_tail[h];
		if (ls_head[h] == NODE_NULL)
			ls_head[h] = n;
		else
			nd_fwd[ls_tail[h]] = n;
		ls_tail[h] = n;
		ls_cur[h] = n;
		ls_len[h]++;
		return 1'b0;
	endfunction

	function automatic logic push_head(int h, logic [ITEM_W-1:0] v);
		logic [PTR_W-1:0] n;
		n = take_node(v);
		if (n == NODE_NULL)
			return 1'b1;
		nd_fwd[n] = ls_head[h];
		if (ls_head[h] == NODE_NULL)
			ls_tail[h] = n;
		else
			nd_bwd[ls_head[h]] = n;
		ls_head[h] = n;
		ls_cur[h] = n;
		ls_len[h]++;
		return 1'b0;
	endfunction

	function automatic logic unlink_cursor(int h, output logic [ITEM_W-1:0] item);
		logic [PTR_W-1:0] c;
		c = ls_cur[h];
		item = '0;
		if (c == NODE_NULL)
			return 1'b1;
		item = nd_val[c];
		if (ls_len[h] == 1) begin
			ls_head[h] = NODE_NULL;
			ls_tail[h] = NODE_NULL;
			ls_cur[h] = NODE_NULL;
			ls_past[h] = 1'b1;
		end else if (c == ls_head[h]) begin
			ls_head[h] = nd_fwd[c];
			nd_bwd[ls_head[h]] = NODE_NULL;
			ls_cur[h] = ls_head[h];
		end else if (c == ls_tail[h]) begin
			ls_tail[h] = nd_bwd[c];
			nd_fwd[ls_tail[h]] = NODE_NULL;
			ls_cur[h] = NODE_NULL;
			ls_past[h] = 1'b1;
		end else begin
			nd_fwd[nd_bwd[c]] = nd_fwd[c];
			nd_bwd[nd_fwd[c]] = nd_bwd[c];
			ls_cur[h] = nd_fwd[c];
		end
		ls_len[h]--;
		return_node(c);
		return 1'b0;
	endfunction

	function automatic list_result_t predict_list_op(logic [OP_W-1:0] op, logic [3:0] hh,
			logic [3:0] gg, logic [ITEM_W-1:0] v);
		list_result_t r;
		int h, g;
		logic [PTR_W-1:0] c, n, nx;
		logic st;
		logic [ITEM_W-1:0] item;
		r = '{status: 1'b1, item: '0, count: '0, handle: '0};
		st = 1'b1;
		item = '0;
		h = hh;
		g = gg;
		if (op == OP_CREATE) begin
			if (free_list_head != LIST_NULL) begin
				h = free_list_head;
				free_list_head = ls_link[h];
				ls_live[h] = 1'b1;
				r.status = 1'b0;
				r.count = ls_len[h];
				r.handle = 4'(h);
			end
			return r;
		end
		if (!ls_live[h] || op == OP_UNDEF)
			return r;
		c = ls_cur[h];
		case (op)
			OP_COUNT: st = 1'b0;
			OP_FIRST, OP_LAST: begin
				n = (op == OP_FIRST) ? ls_head[h] : ls_tail[h];
				ls_cur[h] = n;
				if (n != NODE_NULL) begin
					st = 1'b0;
					item = nd_val[n];
				end
			end
			OP_NEXT: begin
				if (c == ls_tail[h]) begin
					ls_past[h] = 1'b1;
					ls_cur[h] = NODE_NULL;
				end else if (c == NODE_NULL) begin
					if (!ls_past[h]) begin
						ls_cur[h] = ls_head[h];
						st = 1'b0;
						item = nd_val[ls_head[h]];
					end
				end else begin
					ls_cur[h] = nd_fwd[c];
					st = 1'b0;
					item = nd_val[nd_fwd[c]];
				end
			end
			OP_PREV: begin
				if (c == ls_head[h]) begin
					ls_past[h] = 1'b0;
					ls_cur[h] = NODE_NULL;
				end else if (c == NODE_NULL) begin
					if (ls_past[h]) begin
						ls_cur[h] = ls_tail[h];
						st = 1'b0;
						item = nd_val[ls_tail[h]];
					end
				end else begin
					ls_cur[h] = nd_bwd[c];
					st = 1'b0;
					item = nd_val[nd_bwd[c]];
				end
			end
			OP_CURR: begin
				if (c != NODE_NULL) begin
					st = 1'b0;
					item = nd_val[c];
				end
			end
			OP_APPEND: st = push_tail(h, v);
			OP_PREPEND: st = push_head(h, v);
			OP_INS_AFTER: begin
				if (ls_len[h] == 0)
					st = push_tail(h, v);
				else if (c == NODE_NULL && !ls_past[h])
					st = push_head(h, v);
				else if (c == NODE_NULL || c == ls_tail[h])
					st = push_tail(h, v);
				else begin
					n = take_node(v);
					if (n != NODE_NULL) begin
						nd_bwd[nd_fwd[c]] = n;
						nd_fwd[n] = nd_fwd[c];
						nd_bwd[n] = c;
						nd_fwd[c] = n;
						ls_cur[h] = n;
						ls_len[h]++;
						st = 1'b0;
					end
				end
			end
			OP_INS_BEFORE: begin
				if (ls_len[h] == 0)
					st = push_tail(h, v);
				else if ((c == NODE_NULL && !ls_past[h]) || c == ls_head[h])
					st = push_head(h, v);
				else if (c == NODE_NULL)
					st = push_tail(h, v);
				else begin
					n = take_node(v);
					if (n != NODE_NULL) begin
						nd_fwd[nd_bwd[c]] = n;
						nd_fwd[n] = c;
						nd_bwd[n] = nd_bwd[c];
						nd_bwd[c] = n;
						ls_cur[h] = n;
						ls_len[h]++;
						st = 1'b0;
					end
				end
			end
			OP_REMOVE: st = unlink_cursor(h, item);
			OP_TRIM: begin
				if (ls_len[h] != 0) begin
					ls_cur[h] = ls_tail[h];
					st = unlink_cursor(h, item);
					ls_cur[h] = ls_tail[h];
				end
			end
			OP_CONCAT: begin
				if (g != h && ls_live[g]) begin
					if (ls_head[g] != NODE_NULL) begin
						if (ls_head[h] == NODE_NULL)
							ls_head[h] = ls_head[g];
						else begin
							nd_fwd[ls_tail[h]] = ls_head[g];
							nd_bwd[ls_head[g]] = ls_tail[h];
						end
						ls_tail[h] = ls_tail[g];
					end
					ls_len[h] += ls_len[g];
					release_list(g);
					st = 1'b0;
				end
			end
			OP_FREE: begin
				n = ls_head[h];
				while (n != NODE_NULL) begin
					nx = nd_fwd[n];
					return_node(n);
					n = nx;
				end
				release_list(h);
				st = 1'b0;
			end
			default: ;
		endcase
		r.status = st;
		r.item = st ? '0 : item;
		r.count = ls_len[h];
		return r;
	endfunction

	task automatic send_op(logic [OP_W-1:0] op, logic [3:0] h, logic [3:0] g,
			logic [ITEM_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		list_handle <= h;
		second_handle <= g;
		item_word <= v;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_list_op(op, h, g, v));
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [3:0] pick_live_handle();
		logic [3:0] live[$];
		for (int i = 0; i < LISTS; i++)
			if (ls_live[i])
				live.push_back(4'(i));
		if (live.size() == 0 || $urandom_range(0, 19) == 0)
			return 4'($urandom);
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	// receiver stall pattern: always ready, coin flip, or mostly stalled
	always @(posedge clk) begin
		case ((cycles / 97) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 6) == 0);
		endcase
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transaction: st=%0d item=%h cnt=%0d h=%0d",
						status, result_item, result_count, new_handle);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== status || want.item !== result_item ||
						want.count !== result_count || want.handle !== new_handle) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st=%0d item=%h cnt=%0d h=%0d, got st=%0d item=%h cnt=%0d h=%0d",
							want.status, want.item, want.count, want.handle,
							status, result_item, result_count, new_handle);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic test_directed();
		// handle never created
		send_op(OP_COUNT, 4'd15, 4'd0, '0);
		send_op(OP_CREATE, 4'd0, 4'd0, '0);
		send_op(OP_NEXT, 4'd0, 4'd0, '0);
		send_op(OP_PREV, 4'd0, 4'd0, '0);
		send_op(OP_REMOVE, 4'd0, 4'd0, '0);
		send_op(OP_TRIM, 4'd0, 4'd0, '0);
		send_op(OP_INS_BEFORE, 4'd0, 4'd0, 32'hffff_ffff);
		send_op(OP_INS_AFTER, 4'd0, 4'd0, 32'h0000_0000);
		send_op(OP_PREPEND, 4'd0, 4'd0, 32'h8000_0001);
		send_op(OP_APPEND, 4'd0, 4'd0, 32'h7fff_fffe);
		send_op(OP_FIRST, 4'd0, 4'd0, '0);
		send_op(OP_NEXT, 4'd0, 4'd0, '0);
		send_op(OP_INS_AFTER, 4'd0, 4'd0, 32'h1234_5678);
		send_op(OP_INS_BEFORE, 4'd0, 4'd0, 32'h5555_aaaa);
		send_op(OP_PREV, 4'd0, 4'd0, '0);
		send_op(OP_REMOVE, 4'd0, 4'd0, '0);
		send_op(OP_LAST, 4'd0, 4'd0, '0);
		send_op(OP_NEXT, 4'd0, 4'd0, '0);
		send_op(OP_CURR, 4'd0, 4'd0, '0);
		send_op(OP_PREV, 4'd0, 4'd0, '0);
		send_op(OP_TRIM, 4'd0, 4'd0, '0);
		send_op(OP_CREATE, 4'd0, 4'd0, '0);
		send_op(OP_CONCAT, 4'd0, 4'd0, '0);
		send_op(OP_CONCAT, 4'd0, 4'd1, '0);
		send_op(OP_UNDEF, 4'd0, 4'd0, '0);
		send_op(OP_FREE, 4'd0, 4'd0, '0);
	endtask

	task automatic test_handle_pool_empty();
		repeat (LISTS + 1)
			send_op(OP_CREATE, 4'($urandom), 4'($urandom), $urandom);
		send_op(OP_CONCAT, 4'd3, 4'd12, '0);
		send_op(OP_CONCAT, 4'd12, 4'd12, '0);
		for (int i = 0; i < LISTS; i++)
			send_op(OP_FREE, 4'(i), 4'd0, '0);
	endtask

	task automatic test_node_pool_empty();
		logic [3:0] h;
		send_op(OP_CREATE, 4'd0, 4'd0, '0);
		h = pick_live_handle();
		send_op(OP_CREATE, 4'd0, 4'd0, '0);
		repeat (NODES + 2)
			send_op(($urandom_range(0, 1) != 0) ? OP_APPEND : OP_PREPEND, h, 4'd0, $urandom);
		send_op(OP_FIRST, h, 4'd0, '0);
		send_op(OP_NEXT, h, 4'd0, '0);
		send_op(OP_INS_AFTER, h, 4'd0, $urandom);
		send_op(OP_INS_BEFORE, h, 4'd0, $urandom);
		send_op(OP_REMOVE, h, 4'd0, '0);
		send_op(OP_INS_BEFORE, h, 4'd0, $urandom);
		send_op(OP_TRIM, h, 4'd0, '0);
		send_op(OP_FREE, h, 4'd0, '0);
	endtask

	task automatic test_random_ops(int n);
		logic [OP_W-1:0] op;
		int w;
		repeat (n) begin
			w = $urandom_range(0, 99);
			if (w < 7) op = OP_CREATE;
			else if (w < 10) op = OP_COUNT;
			else if (w < 15) op = OP_FIRST;
			else if (w < 20) op = OP_LAST;
			else if (w < 30) op = OP_NEXT;
			else if (w < 38) op = OP_PREV;
			else if (w < 42) op = OP_CURR;
			else if (w < 54) op = OP_APPEND;
			else if (w < 61) op = OP_PREPEND;
			else if (w < 69) op = OP_INS_AFTER;
			else if (w < 77) op = OP_INS_BEFORE;
			else if (w < 87) op = OP_REMOVE;
			else if (w < 93) op = OP_TRIM;
			else if (w < 97) op = OP_CONCAT;
			else if (w < 99) op = OP_FREE;
			else op = OP_UNDEF;
			send_op(op, pick_live_handle(), pick_live_handle(), $urandom);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_handle_pool_empty();
		wait_results_drained();
		test_node_pool_empty();
		test_random_ops(200);
		wait_results_drained();
		test_random_ops(220);
		wait_results_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

FILE: filelist.f
src/pdll_pkg.sv
src/pdll_node_mem.sv
src/pooled_doubly_linked_list_unit.sv
src/pdll_checker.sv
dv/testbench.sv
